@@ hdl/tqpi_pkg.sv @@
`timescale 1ns / 1ps

package tqpi_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int HANDLE_WIDTH_DEF = 32;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_PRIO = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic       commit;
        logic       pop_ok;
        logic [1:0] status;
    } t_res;

endpackage

@@ hdl/tqpi_payload_store.sv @@
`timescale 1ns / 1ps

module tqpi_payload_store #(
    parameter int DEPTH        = tqpi_pkg::DEPTH_DEF,
    parameter int HANDLE_WIDTH = tqpi_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [HANDLE_WIDTH-1:0]  i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [HANDLE_WIDTH-1:0]  o_rdata
);

    logic [HANDLE_WIDTH-1:0] r_mem [DEPTH];
    logic [HANDLE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tqpi_ctrl.sv @@
`timescale 1ns / 1ps

module tqpi_ctrl #(
    parameter int DEPTH = tqpi_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [1:0]                 i_op,
    output logic                       o_in_stall,
    input  logic                       i_out_free,
    output tqpi_pkg::t_res             o_res,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                       o_pl_we,
    output logic [$clog2(DEPTH)-1:0]   o_pl_waddr,
    output logic                       o_pl_re,
    output logic [$clog2(DEPTH)-1:0]   o_pl_raddr
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    t_state         r_state, n_state;
    logic [1:0]     r_op, n_op;
    logic [AW-1:0]  r_head, n_head;
    logic [AW-1:0]  r_tail, n_tail;
    logic [AW-1:0]  r_marker, n_marker;
    logic           r_mvalid, n_mvalid;
    logic [AW-1:0]  r_free_head, n_free_head;
    logic [CW-1:0]  r_fresh, n_fresh;
    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_new, n_new;

    logic [AW-1:0]  r_link [DEPTH];
    logic [AW-1:0]  r_rd_a;
    logic [AW-1:0]  r_rd_b;

    logic           w_accept;
    logic           w_recyc;
    logic           w_full;
    logic [AW-1:0]  w_slot;
    logic           w_lk_we;
    logic [AW-1:0]  w_lk_waddr;
    logic [AW-1:0]  w_lk_wdata;
    logic [AW-1:0]  w_lk_raddr_a;
    tqpi_pkg::t_res w_res;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_recyc  = (r_fresh != r_count);
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_slot   = w_recyc ? r_free_head : r_fresh[AW-1:0];

    assign w_lk_raddr_a = (i_op == tqpi_pkg::OP_POP) ? r_head : r_marker;

    always_ff @(posedge i_clk) begin
        if (w_lk_we) begin
            r_link[w_lk_waddr] <= w_lk_wdata;
        end
        if (w_accept) begin
            r_rd_a <= r_link[w_lk_raddr_a];
            r_rd_b <= r_link[r_free_head];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_head      = r_head;
        n_tail      = r_tail;
        n_marker    = r_marker;
        n_mvalid    = r_mvalid;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_count     = r_count;
        n_new       = r_new;
        w_lk_we     = 1'b0;
        w_lk_waddr  = r_new;
        w_lk_wdata  = r_rd_a;
        w_res       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_op;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_out_free) begin
                    n_state      = S_IDLE;
                    w_res.commit = 1'b1;
                    w_res.status = tqpi_pkg::ST_OK;
                    unique case (r_op) inside
                        tqpi_pkg::OP_PUSH, tqpi_pkg::OP_PRIO: begin
                            if (w_full) begin
                                w_res.status = tqpi_pkg::ST_FULL;
                            end else begin
                                if (w_recyc) begin
                                    n_free_head = r_rd_b;
                                end else begin
                                    n_fresh = r_fresh + CW'(1);
                                end
                                n_count = r_count + CW'(1);
                                if (r_count == '0) begin
                                    n_head = w_slot;
                                    n_tail = w_slot;
                                    if (r_op == tqpi_pkg::OP_PRIO || !r_mvalid) begin
                                        n_marker = w_slot;
                                        n_mvalid = 1'b1;
                                    end
                                end else if (r_op == tqpi_pkg::OP_PUSH) begin
                                    w_lk_we    = 1'b1;
                                    w_lk_waddr = r_tail;
                                    w_lk_wdata = w_slot;
                                    n_tail     = w_slot;
                                    if (!r_mvalid) begin
                                        n_marker = w_slot;
                                        n_mvalid = 1'b1;
                                    end
                                end else if (r_mvalid) begin
                                    // link marker to new entry now, new entry to old successor next
                                    w_lk_we    = 1'b1;
                                    w_lk_waddr = r_marker;
                                    w_lk_wdata = w_slot;
                                    if (r_marker == r_tail) begin
                                        n_tail = w_slot;
                                    end
                                    n_new    = w_slot;
                                    n_marker = w_slot;
                                    n_state  = S_LINK;
                                end else begin
                                    w_lk_we    = 1'b1;
                                    w_lk_waddr = w_slot;
                                    w_lk_wdata = r_head;
                                    n_head     = w_slot;
                                    n_marker   = w_slot;
                                    n_mvalid   = 1'b1;
                                end
                            end
                        end
                        tqpi_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                w_res.status = tqpi_pkg::ST_EMPTY;
                            end else begin
                                w_res.pop_ok = 1'b1;
                                if (r_mvalid && r_marker == r_head) begin
                                    n_mvalid = 1'b0;
                                end
                                n_head      = r_rd_a;
                                w_lk_we     = 1'b1;
                                w_lk_waddr  = r_head;
                                w_lk_wdata  = r_free_head;
                                n_free_head = r_head;
                                n_count     = r_count - CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LINK: begin
                w_lk_we    = 1'b1;
                w_lk_waddr = r_new;
                w_lk_wdata = r_rd_a;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= tqpi_pkg::OP_PUSH;
            r_head      <= '0;
            r_tail      <= '0;
            r_marker    <= '0;
            r_mvalid    <= 1'b0;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_count     <= '0;
            r_new       <= '0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_marker    <= n_marker;
            r_mvalid    <= n_mvalid;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_count     <= n_count;
            r_new       <= n_new;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_res      = w_res;
    assign o_count    = n_count;
    assign o_pl_we    = w_accept && !w_full &&
                        (i_op == tqpi_pkg::OP_PUSH || i_op == tqpi_pkg::OP_PRIO);
    assign o_pl_waddr = w_slot;
    assign o_pl_re    = w_accept && (i_op == tqpi_pkg::OP_POP);
    assign o_pl_raddr = r_head;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_fresh_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh >= r_count)
        else $error("fresh slot count below entry count");

    a_marker_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mvalid |-> (r_count != '0))
        else $error("marker set on empty queue");

    a_link_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> ($past(r_state) == S_EXEC && $past(w_res.commit)))
        else $error("link fix-up without a committed insert");
`endif

endmodule

@@ hdl/task_queue_with_priority_insert_unit.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_stall    | i_operation, i_task_handle
// out     | output    | o_out_valid / i_out_stall  | o_task_out, o_status,
//         |           |                            | o_entry_count, o_not_empty
//
// One operation at a time: memory read on the accept cycle, update and link write in S_EXEC;
// a priority push behind a set marker also passes through S_LINK, since the single link write
// port takes two link updates.
// The result lands in the output register; a waiting result stalls only the update cycle.
// Reset is synchronous, active low; no memory clearing pass (fresh slots are counted).

module task_queue_with_priority_insert_unit #(
    parameter int DEPTH        = tqpi_pkg::DEPTH_DEF,
    parameter int HANDLE_WIDTH = tqpi_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_operation,
    input  logic [HANDLE_WIDTH-1:0]    i_task_handle,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [HANDLE_WIDTH-1:0]    o_task_out,
    output logic [1:0]                 o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_entry_count,
    output logic                       o_not_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tqpi_pkg::t_res          w_res;
    logic [CW-1:0]           w_count;
    logic                    w_out_free;
    logic                    w_pl_we;
    logic [AW-1:0]           w_pl_waddr;
    logic                    w_pl_re;
    logic [AW-1:0]           w_pl_raddr;
    logic [HANDLE_WIDTH-1:0] w_pl_rdata;

    logic                    r_out_valid;
    logic [HANDLE_WIDTH-1:0] r_task_out;
    logic [1:0]              r_status;
    logic [CW-1:0]           r_count;
    logic                    r_not_empty;

    assign w_out_free = !r_out_valid || !i_out_stall;

    tqpi_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_operation),
        .o_in_stall (o_in_stall),
        .i_out_free (w_out_free),
        .o_res      (w_res),
        .o_count    (w_count),
        .o_pl_we    (w_pl_we),
        .o_pl_waddr (w_pl_waddr),
        .o_pl_re    (w_pl_re),
        .o_pl_raddr (w_pl_raddr)
    );

    tqpi_payload_store #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_payload (
        .i_clk   (i_clk),
        .i_we    (w_pl_we),
        .i_waddr (w_pl_waddr),
        .i_wdata (i_task_handle),
        .i_re    (w_pl_re),
        .i_raddr (w_pl_raddr),
        .o_rdata (w_pl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.commit) begin
            r_task_out  <= w_res.pop_ok ? w_pl_rdata : '0;
            r_status    <= w_res.status;
            r_count     <= w_count;
            r_not_empty <= (w_count != '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_task_out    = r_task_out;
    assign o_status      = r_status;
    assign o_entry_count = r_count;
    assign o_not_empty   = r_not_empty;

endmodule
